// ===== src/dmc_pkg.sv =====
// Shared types and constants for the direct-mapped cache tag check.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

	localparam int ADDR_W  = 32;
	localparam int TAG_W   = 28;
	localparam int LINE_W  = 14;
	localparam int LINES   = 1 << LINE_W;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 4;
	localparam int SHIFT_W = 4;

	localparam logic [SHIFT_W-1:0] OFF_MIN = 4'd4;
	localparam logic [SHIFT_W-1:0] OFF_MAX = 4'd8;
	localparam logic [SHIFT_W-1:0] IDX_MAX = 4'd14;

	localparam logic [SHIFT_W-1:0] OFF_RESET = 4'd4;
	localparam logic [SHIFT_W-1:0] IDX_RESET = 4'd8;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_OFFSET = 1'b0,
		REG_INDEX  = 1'b1
	} cfg_reg_t;

	// one classified item, front to back
	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic [TAG_W-1:0]  tag;
	} req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic clearing;
		logic working;
	} back_stat_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK
	} back_state_t;

endpackage

`default_nettype wire

// ===== src/dmc_front.sv =====
// Front part: holds the configuration and splits each address into line and tag.
// Depends on dmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmc_front import dmc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic              wr_en,
	input  wire logic              wr_index,
	input  wire logic [CFG_W-1:0]  wr_data,
	output logic                   push,
	output req_t                   req
);

	logic [SHIFT_W-1:0] off_q;
	logic [SHIFT_W-1:0] idx_q;
	logic [SHIFT_W-1:0] off_eff;
	logic [SHIFT_W-1:0] idx_eff;
	logic [LINE_W:0]    line_mask;
	logic [ADDR_W-1:0]  addr_line;
	logic [ADDR_W-1:0]  addr_tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= OFF_RESET;
			idx_q <= IDX_RESET;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_OFFSET: off_q <= wr_data;
				REG_INDEX:  idx_q <= wr_data;
				default:    off_q <= off_q;
			endcase
		end
	end

	always_comb begin
		priority if (off_q < OFF_MIN) begin
			off_eff = OFF_MIN;
		end else if (off_q > OFF_MAX) begin
			off_eff = OFF_MAX;
		end else begin
			off_eff = off_q;
		end
		idx_eff = (idx_q > IDX_MAX) ? IDX_MAX : idx_q;
	end

	assign line_mask = ((LINE_W+1)'(1) << idx_eff) - (LINE_W+1)'(1);
	assign addr_line = address >> off_eff;
	assign addr_tag  = address >> (5'(off_eff) + 5'(idx_eff));

	assign push     = start && !busy;
	assign req.line = addr_line[LINE_W-1:0] & line_mask[LINE_W-1:0];
	assign req.tag  = addr_tag[TAG_W-1:0];

endmodule

`default_nettype wire

// ===== src/dmc_queue.sv =====
// Two-entry queue of classified items between front and back.
// Depends on dmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmc_queue import dmc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  req_t      push_req,
	input  wire logic pop,
	output req_t      head,
	output q_stat_t   stat
);

	req_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign stat.empty = (count_q == 2'd0);
	assign stat.full  = (count_q == 2'd2);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

`default_nettype wire

// ===== src/dmc_back.sv =====
// Back part: tag store with valid marks, clearing pass, compare, counters, result.
// Depends on dmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmc_back import dmc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  q_stat_t                q_stat,
	input  req_t                   head,
	output logic                   pop,
	output back_stat_t             stat,
	output logic                   done,
	output logic                   hit,
	output logic [LINE_W-1:0]      line_index,
	output logic [CNT_W-1:0]       hit_total,
	output logic [CNT_W-1:0]       miss_total
);

	// entry: valid mark above the tag
	logic [TAG_W:0]    mem [LINES];
	logic [TAG_W:0]    rd_data_q;
	logic [LINE_W-1:0] clr_addr_q;
	back_state_t       state_q;
	back_state_t       state_d;
	req_t              cur_q;
	logic              mem_we;
	logic [LINE_W-1:0] mem_wa;
	logic [TAG_W:0]    mem_wd;
	logic              is_hit;
	logic              check;
	logic              done_q;
	logic              hit_q;
	logic [LINE_W-1:0] line_q;
	logic [CNT_W-1:0]  hit_cnt_q;
	logic [CNT_W-1:0]  miss_cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == {LINE_W{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_stat.empty) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		pop            = (state_q == ST_IDLE) && !q_stat.empty;
		check          = (state_q == ST_CHECK);
		stat.clearing  = (state_q == ST_CLEAR);
		stat.working   = check;
		is_hit         = rd_data_q[TAG_W] && (rd_data_q[TAG_W-1:0] == cur_q.tag);
		mem_we         = stat.clearing || (check && !is_hit);
		mem_wa         = stat.clearing ? clr_addr_q : cur_q.line;
		mem_wd         = stat.clearing ? '0 : {1'b1, cur_q.tag};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[head.line];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (check) begin
			hit_q  <= is_hit;
			line_q <= cur_q.line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= check;
			if (stat.clearing) begin
				clr_addr_q <= clr_addr_q + LINE_W'(1);
			end
			if (check && is_hit) begin
				hit_cnt_q <= hit_cnt_q + CNT_W'(1);
			end
			if (check && !is_hit) begin
				miss_cnt_q <= miss_cnt_q + CNT_W'(1);
			end
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign line_index = line_q;
	assign hit_total  = hit_cnt_q;
	assign miss_total = miss_cnt_q;

endmodule

`default_nettype wire

// ===== src/direct_mapped_cache_tag_check.sv =====
// Top level of the direct-mapped cache tag check: front, queue and back.
// Depends on dmc_pkg, dmc_front, dmc_queue, dmc_back.
//
// channel   ports                                       handshake
// config    wr_en, wr_index, wr_data                    write when wr_en high
// item in   address                                     start & !busy
// result    hit, line_index, hit_total, miss_total      done strobe, one cycle
//
// An item's done strobe follows its acceptance through these steps: queue write, then
// tag read (registered memory read) as it leaves the queue, then compare and
// update into the result registers. busy stays high until the item has left
// the tag store, so a new item is not accepted before the previous one is compared.
// After reset a clearing pass over the 16384-line tag store runs with busy
// high. Results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_cache_tag_check import dmc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic              wr_en,
	input  wire logic              wr_index,
	input  wire logic [CFG_W-1:0]  wr_data,
	output logic                   done,
	output logic                   hit,
	output logic [LINE_W-1:0]      line_index,
	output logic [CNT_W-1:0]       hit_total,
	output logic [CNT_W-1:0]       miss_total
);

	logic       push;
	logic       pop;
	req_t       req;
	req_t       head;
	q_stat_t    q_stat;
	back_stat_t b_stat;

	assign busy = b_stat.clearing || b_stat.working || !q_stat.empty;

	dmc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.address  (address),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.req      (req)
	);

	dmc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (req),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	dmc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head       (head),
		.pop        (pop),
		.stat       (b_stat),
		.done       (done),
		.hit        (hit),
		.line_index (line_index),
		.hit_total  (hit_total),
		.miss_total (miss_total)
	);

endmodule

`default_nettype wire

// ===== src/dmc_checker.sv =====
// Port-level checks for direct_mapped_cache_tag_check, bound to the top level.
// Depends on dmc_pkg and direct_mapped_cache_tag_check.
`timescale 1ns / 1ps
`default_nettype none

module dmc_checker import dmc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic              hit,
	input wire logic [CNT_W-1:0]  hit_total,
	input wire logic [CNT_W-1:0]  miss_total
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after an item was accepted");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without work in the cycle before");

	a_count_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> (hit_total == $past(hit_total) + CNT_W'(1))
			&& (miss_total == $past(miss_total)))
		else $error("counters wrong after a hit");

	a_count_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> (miss_total == $past(miss_total) + CNT_W'(1))
			&& (hit_total == $past(hit_total)))
		else $error("counters wrong after a miss");

endmodule

bind direct_mapped_cache_tag_check dmc_checker u_dmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.hit        (hit),
	.hit_total  (hit_total),
	.miss_total (miss_total)
);

`default_nettype wire
